// ===== src/keyed_record_stack_unit_macros.svh =====
// assertion macros shared by the keyed record stack rtl
// no dependencies; included by the files that carry assertions
`ifndef KEYED_RECORD_STACK_UNIT_MACROS_SVH
`define KEYED_RECORD_STACK_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define KRS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed record stack: implication check failed");

// next-cycle implication, disabled while reset is high
`define KRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed record stack: next-cycle check failed");

`endif

// ===== src/krs_pkg.sv =====
// shared types and constants of the keyed record stack
// no dependencies; imported by krs_ctrl, krs_dp and keyed_record_stack_unit
package krs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 16;
  localparam int VAL_W     = 16;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 3;

  // command codes of an input word
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH       = 2'd0,
    CMD_POP        = 2'd1,
    CMD_FIND_KEY   = 2'd2,
    CMD_FIND_VALUE = 2'd3
  } command_t;

  // status codes of a result word
  typedef enum logic [STAT_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NOTFOUND  = 3'd6
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_en;
    logic    emit;
    status_t emit_status;
    logic    emit_pend;
    logic    emit_last;
    logic    push_write;
    logic    pop;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    command_t cmd;
    logic     empty;
    logic     full;
    logic     scan_done;
    logic     hit;
    logic     pend_valid;
  } sts_t;

endpackage

// ===== src/krs_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
module krs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/krs_ctrl.sv =====
// controller state machine of the keyed record stack
// depends on krs_pkg
module krs_ctrl import krs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.cmd == CMD_POP || (sts.cmd == CMD_PUSH && sts.full) ||
            (sts.cmd != CMD_PUSH && sts.empty)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    ctl.emit_status = ST_ADDED;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        ctl.load = start;
      end
      // answers that need no scan
      S_CHECK: begin
        ctl.emit_last = 1'b1;
        unique case (sts.cmd) inside
          CMD_POP: begin
            ctl.emit = 1'b1;
            ctl.emit_status = sts.empty ? ST_EMPTY : ST_REMOVED;
            ctl.pop = !sts.empty;
          end
          CMD_PUSH: begin
            ctl.emit = sts.full;
            ctl.emit_status = ST_FULL;
          end
          CMD_FIND_KEY, CMD_FIND_VALUE: begin
            ctl.emit = sts.empty;
            ctl.emit_status = ST_EMPTY;
          end
          default: ctl.emit = 1'b0;
        endcase
      end
      // a new value match pushes out the one held before it
      S_SCAN: begin
        ctl.scan_en = 1'b1;
        if (sts.cmd == CMD_FIND_VALUE && sts.hit && sts.pend_valid) begin
          ctl.emit = 1'b1;
          ctl.emit_status = ST_FOUND;
          ctl.emit_pend = 1'b1;
        end
      end
      // final word of a scanned command
      S_FINISH: begin
        ctl.emit_last = 1'b1;
        unique case (sts.cmd) inside
          CMD_PUSH: begin
            ctl.emit = 1'b1;
            ctl.emit_status = sts.pend_valid ? ST_DUPLICATE : ST_ADDED;
            ctl.push_write = !sts.pend_valid;
          end
          CMD_FIND_KEY, CMD_FIND_VALUE: begin
            ctl.emit = 1'b1;
            ctl.emit_status = sts.pend_valid ? ST_FOUND : ST_NOTFOUND;
            ctl.emit_pend = sts.pend_valid;
          end
          default: ctl.emit = 1'b0;
        endcase
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== src/krs_dp.sv =====
// datapath of the keyed record stack: record memory, fill count, scan, result register
// depends on krs_pkg, krs_ram and keyed_record_stack_unit_macros.svh
`include "keyed_record_stack_unit_macros.svh"

module krs_dp import krs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic [CMD_W-1:0]  command,
  input  logic [KEY_W-1:0]  record_key,
  input  logic [VAL_W-1:0]  record_value,
  output logic              strobe,
  output logic [STAT_W-1:0] status,
  output logic [KEY_W-1:0]  found_key,
  output logic [VAL_W-1:0]  found_value,
  output logic              last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  command_t          cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     idx;
  logic              rd_vld;
  logic              pend_valid;
  logic [KEY_W-1:0]  pend_key;
  logic [VAL_W-1:0]  pend_val;
  logic              issue;
  logic              match;
  logic              hit;
  logic [KEY_W+VAL_W-1:0] rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [VAL_W-1:0]  rd_val;

  // record memory, key in the upper half
  krs_ram #(
    .WIDTH(KEY_W + VAL_W),
    .DEPTH(DEPTH)
  ) u_rec_ram (
    .clk  (clk),
    .we   (ctl.push_write),
    .waddr(fill[AW-1:0]),
    .wdata({key_q, val_q}),
    .re   (issue),
    .raddr(idx[AW-1:0]),
    .rdata(rdata)
  );

  assign rd_key = rdata[KEY_W+VAL_W-1:VAL_W];
  assign rd_val = rdata[VAL_W-1:0];

  // scan compare: value for a value search, key otherwise
  assign issue = ctl.scan_en && (idx != fill);
  assign match = (cmd_q == CMD_FIND_VALUE) ? (rd_val == val_q) : (rd_key == key_q);
  assign hit   = rd_vld && match;

  // input word latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= command_t'(command);
      key_q <= record_key;
      val_q <= record_value;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.push_write) begin
      fill <= fill + 1'b1;
    end else if (ctl.pop) begin
      fill <= fill - 1'b1;
    end
  end

  // scan index and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (ctl.load) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // held match
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctl.load) begin
      pend_valid <= 1'b0;
    end else if (hit) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pend_key <= rd_key;
      pend_val <= rd_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status      <= ctl.emit_status;
      found_key   <= ctl.emit_pend ? pend_key : '0;
      found_value <= ctl.emit_pend ? pend_val : '0;
      last        <= ctl.emit_last;
    end
  end

  // status to the controller
  always_comb begin
    sts.cmd        = cmd_q;
    sts.empty      = (fill == '0);
    sts.full       = (fill == CW'(DEPTH));
    sts.scan_done  = (idx == fill) && !rd_vld;
    sts.hit        = hit;
    sts.pend_valid = pend_valid;
  end

  `KRS_ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill <= CW'(DEPTH))
  `KRS_ASSERT_IMPLY(a_push_room, clk, rst, ctl.push_write, fill != CW'(DEPTH))
  `KRS_ASSERT_IMPLY(a_pop_held, clk, rst, ctl.pop, fill != '0)
  `KRS_ASSERT_IMPLY(a_pend_emit, clk, rst, ctl.emit && ctl.emit_pend, pend_valid)
  `KRS_ASSERT_NEXT(a_push_count, clk, rst, ctl.push_write, fill == $past(fill) + 1'b1)

endmodule

// ===== src/keyed_record_stack_unit.sv =====
// Keyed record stack: a bounded stack of unique-key records with key and value search.
// Command port: pulse start with command, record_key and record_value while busy is
// low; the word is taken at that edge and busy rises until the command is done.
// Result port: each result word sits on status, found_key, found_value and last for
// one cycle, marked by strobe; last is high on the final word of a command. The
// receiver cannot hold results off and the block never waits on it.
// Command flow: pop, and push to a full stack or any search of an empty stack, keep
// busy through the check state only and give their word in the cycle after it.
// Push, key lookup and value search otherwise keep busy through the check state, a
// scan that makes one memory read per record, a wait for the last read to land, the
// close of the scan and the answer state; the record memory has one read port and
// the scan reads one record per cycle. Value search words come out as matches are
// found; the final one, marked last, appears the cycle after busy falls, as do the
// single words of the other commands. A new command may be started in the same
// cycle as that final word is shown, and the block takes one command at a time.
// Reset (rst, synchronous) empties the stack; stored records need no clearing.
// depends on krs_pkg, krs_ctrl and krs_dp
module keyed_record_stack_unit import krs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command,
  input  logic [KEY_W-1:0]  record_key,
  input  logic [VAL_W-1:0]  record_value,
  output logic              strobe,
  output logic [STAT_W-1:0] status,
  output logic [KEY_W-1:0]  found_key,
  output logic [VAL_W-1:0]  found_value,
  output logic              last
);

  ctl_t ctl;
  sts_t sts;

  // sequencing
  krs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  // storage, scan and result register
  krs_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .record_key  (record_key),
    .record_value(record_value),
    .strobe      (strobe),
    .status      (status),
    .found_key   (found_key),
    .found_value (found_value),
    .last        (last)
  );

endmodule

// ===== verif/keyed_record_stack_unit_test.sv =====
// testbench of keyed_record_stack_unit: directed and random stack commands, each result
// word checked field by field against a stack model kept inside the bench
// depends on krs_pkg and the keyed_record_stack_unit rtl
module keyed_record_stack_unit_test import krs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = DEPTH_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int KEY_POOL_N  = 32;
  localparam int VAL_POOL_N  = 4;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             last;
  } result_word_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  command;
  logic [KEY_W-1:0]  record_key;
  logic [VAL_W-1:0]  record_value;
  logic              strobe;
  logic [STAT_W-1:0] status;
  logic [KEY_W-1:0]  found_key;
  logic [VAL_W-1:0]  found_value;
  logic              last;

  // stack model state
  logic [KEY_W-1:0] model_keys [STACK_DEPTH];
  logic [VAL_W-1:0] model_values [STACK_DEPTH];
  int               model_fill = 0;

  result_word_t     pending_results [$];
  int               mismatch_count = 0;
  int               idle_cycles = 0;
  logic [KEY_W-1:0] key_pool [KEY_POOL_N];
  logic [VAL_W-1:0] value_pool [VAL_POOL_N];

  keyed_record_stack_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .record_key   (record_key),
    .record_value (record_value),
    .strobe       (strobe),
    .status       (status),
    .found_key    (found_key),
    .found_value  (found_value),
    .last         (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  function automatic void expect_word(status_t s, logic [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v, logic fin);
    result_word_t w;
    w.status = s;
    w.key    = k;
    w.value  = v;
    w.last   = fin;
    pending_results.push_back(w);
  endfunction

  // update the stack model and queue the words one command produces
  function automatic void predict_stack_op(command_t c, logic [KEY_W-1:0] k,
                                           logic [VAL_W-1:0] v);
    int where;
    int hits;
    int seen;
    where = -1;
    hits  = 0;
    seen  = 0;
    for (int i = 0; i < model_fill; i++) begin
      if (where < 0 && model_keys[i] == k) where = i;
    end
    case (c)
      CMD_PUSH: begin
        if (model_fill >= STACK_DEPTH) begin
          expect_word(ST_FULL, '0, '0, 1'b1);
        end else if (where >= 0) begin
          expect_word(ST_DUPLICATE, '0, '0, 1'b1);
        end else begin
          model_keys[model_fill]   = k;
          model_values[model_fill] = v;
          model_fill++;
          expect_word(ST_ADDED, '0, '0, 1'b1);
        end
      end
      CMD_POP: begin
        if (model_fill == 0) begin
          expect_word(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          model_fill--;
          expect_word(ST_REMOVED, '0, '0, 1'b1);
        end
      end
      CMD_FIND_KEY: begin
        if (model_fill == 0) begin
          expect_word(ST_EMPTY, '0, '0, 1'b1);
        end else if (where >= 0) begin
          expect_word(ST_FOUND, model_keys[where], model_values[where], 1'b1);
        end else begin
          expect_word(ST_NOTFOUND, '0, '0, 1'b1);
        end
      end
      default: begin
        // value search: every match from the bottom of the stack up
        if (model_fill == 0) begin
          expect_word(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < model_fill; i++) begin
            if (model_values[i] == v) hits++;
          end
          if (hits == 0) begin
            expect_word(ST_NOTFOUND, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < model_fill; i++) begin
              if (model_values[i] == v) begin
                seen++;
                expect_word(ST_FOUND, model_keys[i], model_values[i], seen == hits);
              end
            end
          end
        end
      end
    endcase
  endfunction

  // drive one command word and hold it until the block takes it
  task automatic send_word(command_t c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    start        <= 1'b1;
    command      <= c;
    record_key   <= k;
    record_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    predict_stack_op(c, k, v);
  endtask

  // random commands over small key and value pools, with optional sender gaps
  task automatic run_random(int count, int idle_pct, int push_pct);
    command_t         c;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int               r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < push_pct) c = CMD_PUSH;
      else if (r < push_pct + 20) c = CMD_FIND_KEY;
      else if (r < push_pct + 40) c = CMD_FIND_VALUE;
      else c = CMD_POP;
      r = $urandom_range(99);
      if (r < 15 && model_fill > 0) k = model_keys[$urandom_range(model_fill - 1)];
      else if (r < 85) k = key_pool[$urandom_range(KEY_POOL_N - 1)];
      else k = KEY_W'($urandom);
      if ($urandom_range(99) < 65) v = value_pool[$urandom_range(VAL_POOL_N - 1)];
      else v = VAL_W'($urandom);
      send_word(c, k, v);
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  endtask

  task automatic test_empty_stack();
    send_word(CMD_POP, '0, '0);
    send_word(CMD_FIND_KEY, 16'hFFFF, '0);
    send_word(CMD_FIND_VALUE, '0, 16'hFFFF);
  endtask

  task automatic test_push_and_lookup();
    send_word(CMD_PUSH, 16'h0000, 16'hFFFF);
    send_word(CMD_PUSH, 16'hFFFF, 16'hFFFF);
    send_word(CMD_PUSH, 16'h0000, 16'h1234);
    send_word(CMD_FIND_KEY, 16'hFFFF, '0);
    send_word(CMD_FIND_KEY, 16'h1234, '0);
    send_word(CMD_FIND_VALUE, '0, 16'h0000);
    send_word(CMD_FIND_VALUE, '0, 16'hFFFF);
  endtask

  // fill to the top, then push a fresh key and a held key
  task automatic test_full_stack();
    for (int i = 1; i <= STACK_DEPTH - 2; i++) begin
      send_word(CMD_PUSH, KEY_W'(i), 16'hFFFF);
    end
    send_word(CMD_PUSH, 16'h8000, 16'h0000);
    send_word(CMD_PUSH, 16'h0000, 16'h0000);
  endtask

  task automatic test_search_all_records();
    send_word(CMD_FIND_VALUE, '0, 16'hFFFF);
  endtask

  task automatic test_random_no_idle();
    run_random(135, 0, 40);
  endtask

  task automatic test_random_sender_idle();
    run_random(135, 68, 32);
  endtask

  task automatic test_random_mixed_idle();
    run_random(135, 33, 30);
  endtask

  // compare each result word with the oldest expected one
  always @(posedge clk) begin : check_words
    result_word_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("word with nothing expected, status %0d", status));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (found_key !== want.key)
          report_mismatch($sformatf("found_key %h, want %h", found_key, want.key));
        if (found_value !== want.value)
          report_mismatch($sformatf("found_value %h, want %h", found_value, want.value));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, want %b", last, want.last));
      end
    end
  end

  // watchdog on cycles with no word taken either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    command      <= CMD_PUSH;
    record_key   <= '0;
    record_value <= '0;
    for (int i = 0; i < KEY_POOL_N; i++) key_pool[i] = KEY_W'($urandom);
    for (int i = 0; i < VAL_POOL_N; i++) value_pool[i] = VAL_W'($urandom);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_push_and_lookup();
    test_full_stack();
    test_search_all_records();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_mixed_idle();

    // drain outstanding words, then watch for strays
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
